>>> hw/rtl/bhf_pkg.sv
// ----------------------------------------------------------------------------
// bhf_pkg
// Shared types and constants for the bar hit filter with geometric mean.
// ----------------------------------------------------------------------------
package bhf_pkg;

    localparam int BarWidth    = 5;
    localparam int ChargeWidth = 12;
    localparam int TimeWidth   = 21;
    localparam int CountWidth  = 6;
    localparam int CountMax    = 63;

    // Radix-4 serial multiply: one 2-bit digit of the multiplier per cycle.
    localparam int ProdWidth   = 2 * ChargeWidth;
    localparam int MulDigits   = ChargeWidth / 2;
    localparam int MulCntWidth = $clog2(MulDigits);

    // Root of (product << 8): 32-bit radicand, one root bit per cycle.
    localparam int RootWidth    = 16;
    localparam int RemWidth     = RootWidth + 1;
    localparam int SqrtSteps    = RootWidth;
    localparam int SqrtCntWidth = $clog2(SqrtSteps);

    typedef struct packed {
        logic [BarWidth-1:0]    bar_index;
        logic [ChargeWidth-1:0] common_left;
        logic [ChargeWidth-1:0] common_right;
        logic [ChargeWidth-1:0] fast_left;
        logic [ChargeWidth-1:0] fast_right;
        logic [TimeWidth-1:0]   time_left;
        logic [TimeWidth-1:0]   time_right;
        logic                   time_left_present;
        logic                   time_right_present;
        logic                   event_last;
    } bar_word_t;

    typedef struct packed {
        logic [BarWidth-1:0]    hit_slot;
        logic [BarWidth-1:0]    hit_bar;
        logic [ChargeWidth-1:0] out_common_left;
        logic [ChargeWidth-1:0] out_common_right;
        logic [ChargeWidth-1:0] out_fast_left;
        logic [ChargeWidth-1:0] out_fast_right;
        logic [TimeWidth-1:0]   out_time_left;
        logic [TimeWidth-1:0]   out_time_right;
        logic [RootWidth-1:0]   geo_mean;
        logic [RootWidth-1:0]   fast_geo_mean;
        logic                   is_hit;
        logic                   event_end;
    } hit_word_t;

endpackage

>>> hw/rtl/bhf_if.sv
// ----------------------------------------------------------------------------
// bhf_bar_if / bhf_hit_if
// Valid/ready channels carrying bar readings in and hit words out.
// ----------------------------------------------------------------------------
interface bhf_bar_if;
    logic               valid;
    logic               ready;
    bhf_pkg::bar_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bhf_hit_if;
    logic               valid;
    logic               ready;
    bhf_pkg::hit_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/bhf_mul.sv
// ----------------------------------------------------------------------------
// bhf_mul
// Radix-4 serial multiplier: 12 x 12 bits, one multiplier digit per cycle.
// ----------------------------------------------------------------------------
module bhf_mul
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [bhf_pkg::ChargeWidth-1:0]   a,
    input  logic [bhf_pkg::ChargeWidth-1:0]   b,
    output logic                              done,
    output logic [bhf_pkg::ProdWidth-1:0]     prod
);

    localparam int Cw = bhf_pkg::ChargeWidth;
    localparam int Pw = Cw + 2;
    localparam logic [bhf_pkg::MulCntWidth-1:0] LastDigit =
        bhf_pkg::MulCntWidth'(bhf_pkg::MulDigits - 1);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [bhf_pkg::MulCntWidth-1:0] cnt_reg, cnt_next;
    logic [Cw-1:0]                   a_reg, a_next;
    logic [Cw-1:0]                   hi_reg, hi_next;
    logic [Cw-1:0]                   lo_reg, lo_next;
    logic [Pw-1:0]                   part;
    logic [Pw-1:0]                   sum;

    // hi stays below a after every shift, so 12 bits hold it
    always_comb
    begin
        part      = Pw'(a_reg) * Pw'(lo_reg[1:0]);
        sum       = Pw'(hi_reg) + part;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            hi_next   = '0;
            lo_next   = b;
        end
        else if (busy_reg)
        begin
            hi_next  = sum[Pw-1:2];
            lo_next  = {sum[1:0], lo_reg[Cw-1:2]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LastDigit)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

>>> hw/rtl/bhf_sqrt.sv
// ----------------------------------------------------------------------------
// bhf_sqrt
// Restoring digit-by-digit square root of (prod << 8), one root bit a cycle.
// ----------------------------------------------------------------------------
module bhf_sqrt
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [bhf_pkg::ProdWidth-1:0]     radicand,
    output logic                              done,
    output logic [bhf_pkg::RootWidth-1:0]     root
);

    localparam int Pw = bhf_pkg::ProdWidth;
    localparam int Rw = bhf_pkg::RootWidth;
    localparam int Mw = bhf_pkg::RemWidth;
    localparam logic [bhf_pkg::SqrtCntWidth-1:0] LastStep =
        bhf_pkg::SqrtCntWidth'(bhf_pkg::SqrtSteps - 1);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [bhf_pkg::SqrtCntWidth-1:0] cnt_reg, cnt_next;
    logic [Pw-1:0]                    rad_reg, rad_next;
    logic [Mw-1:0]                    rem_reg, rem_next;
    logic [Rw-1:0]                    root_reg, root_next;
    logic [Mw+1:0]                    trial_rem;
    logic [Rw+1:0]                    trial_sub;
    logic [Mw+1:0]                    diff;
    logic                             fits;

    // low 8 radicand bits are zero: the shift register feeds zeros once
    // the product bits are used up
    always_comb
    begin
        trial_rem = {rem_reg, rad_reg[Pw-1:Pw-2]};
        trial_sub = {root_reg, 2'b01};
        diff      = trial_rem - (Mw+2)'(trial_sub);
        fits      = (trial_rem >= (Mw+2)'(trial_sub));
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[Pw-3:0], 2'b00};
            cnt_next = cnt_reg + 1'b1;
            if (fits)
            begin
                rem_next  = diff[Mw-1:0];
                root_next = {root_reg[Rw-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial_rem[Mw-1:0];
                root_next = {root_reg[Rw-2:0], 1'b0};
            end
            if (cnt_reg == LastStep)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> hw/rtl/bar_hit_filter_geomean.sv
// ----------------------------------------------------------------------------
// bar_hit_filter_geomean
// Zero suppression of bar readings with Q12.4 geometric means of the charges.
// ----------------------------------------------------------------------------
//  channel  dir  word        handshake
//  bars     in   bar_word_t  valid/ready, taken when both high
//  hits     out  hit_word_t  valid/ready, taken when both high
//
//  A word that yields no result (no hit, not last) is dropped; the sequencer stays idle.
//  A word that yields a result runs a radix-4 serial multiply, then a serial
//  square root, before the result is loaded into the output register.
//  The next word is accepted as soon as the result sits in the output register.
//  Reset clears the hit count and all handshake state.
//  A stalled hits channel holds the sequencer before loading the next result.
// ----------------------------------------------------------------------------
module bar_hit_filter_geomean
#(
    parameter int BAR_COUNT = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    bhf_bar_if.sink  bars,
    bhf_hit_if.source hits
);

    localparam int CapInt = (BAR_COUNT < bhf_pkg::CountMax) ? BAR_COUNT : bhf_pkg::CountMax;
    localparam logic [bhf_pkg::CountWidth-1:0] Cap = bhf_pkg::CountWidth'(CapInt);
    localparam logic [bhf_pkg::CountWidth:0]   BarLimit = (bhf_pkg::CountWidth+1)'(BAR_COUNT);

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StMul  = 2'd1;
    localparam logic [1:0] StSqrt = 2'd2;
    localparam logic [1:0] StLoad = 2'd3;

    logic [1:0]                       state_reg, state_next;
    logic [bhf_pkg::CountWidth-1:0]   hit_count_reg, hit_count_next;
    logic                             out_valid_reg, out_valid_next;
    bhf_pkg::hit_word_t               work_reg, work_next;
    bhf_pkg::hit_word_t               out_reg, out_next;

    logic                             accept;
    logic                             hit;
    logic                             emit;
    logic                             out_free;
    logic [bhf_pkg::ChargeWidth-1:0]  cl_m, cr_m, fl_m, fr_m;

    logic                             mul_start, mul_done, mul_fast_done;
    logic [bhf_pkg::ProdWidth-1:0]    prod_common, prod_fast;
    logic                             sqrt_start, sqrt_done, sqrt_fast_done;
    logic [bhf_pkg::RootWidth-1:0]    root_common, root_fast;

    assign accept   = bars.valid && bars.ready;
    assign out_free = !out_valid_reg || hits.ready;

    assign hit = (bars.data.common_left != '0) && (bars.data.common_right != '0)
               && bars.data.time_left_present && bars.data.time_right_present
               && ((bhf_pkg::CountWidth+1)'(bars.data.bar_index) < BarLimit)
               && (hit_count_reg < Cap);
    assign emit = hit || bars.data.event_last;

    // a closing word without a hit runs through the units on zeros
    assign cl_m = hit ? bars.data.common_left  : '0;
    assign cr_m = hit ? bars.data.common_right : '0;
    assign fl_m = hit ? bars.data.fast_left    : '0;
    assign fr_m = hit ? bars.data.fast_right   : '0;

    assign mul_start  = accept && emit;
    assign sqrt_start = (state_reg == StMul) && mul_done;

    bhf_mul u_mul_common
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (cl_m),
        .b     (cr_m),
        .done  (mul_done),
        .prod  (prod_common)
    );

    bhf_mul u_mul_fast
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (fl_m),
        .b     (fr_m),
        .done  (mul_fast_done),
        .prod  (prod_fast)
    );

    bhf_sqrt u_sqrt_common
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (prod_common),
        .done     (sqrt_done),
        .root     (root_common)
    );

    bhf_sqrt u_sqrt_fast
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (prod_fast),
        .done     (sqrt_fast_done),
        .root     (root_fast)
    );

    always_comb
    begin
        state_next     = state_reg;
        hit_count_next = hit_count_reg;
        out_valid_next = out_valid_reg;
        work_next      = work_reg;
        out_next       = out_reg;

        if (out_valid_reg && hits.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            StIdle:
            begin
                if (accept)
                begin
                    if (bars.data.event_last)
                    begin
                        hit_count_next = '0;
                    end
                    else if (hit)
                    begin
                        hit_count_next = hit_count_reg + 1'b1;
                    end
                    work_next                  = '0;
                    work_next.hit_slot         = hit ? hit_count_reg[bhf_pkg::BarWidth-1:0] : '0;
                    work_next.hit_bar          = hit ? bars.data.bar_index : '0;
                    work_next.out_common_left  = cl_m;
                    work_next.out_common_right = cr_m;
                    work_next.out_fast_left    = fl_m;
                    work_next.out_fast_right   = fr_m;
                    work_next.out_time_left    = hit ? bars.data.time_left  : '0;
                    work_next.out_time_right   = hit ? bars.data.time_right : '0;
                    work_next.is_hit           = hit;
                    work_next.event_end        = bars.data.event_last;
                    if (emit)
                    begin
                        state_next = StMul;
                    end
                end
            end
            StMul:
            begin
                if (mul_done && mul_fast_done)
                begin
                    state_next = StSqrt;
                end
            end
            StSqrt:
            begin
                if (sqrt_done && sqrt_fast_done)
                begin
                    state_next = StLoad;
                end
            end
            StLoad:
            begin
                if (out_free)
                begin
                    out_next               = work_reg;
                    out_next.geo_mean      = root_common;
                    out_next.fast_geo_mean = root_fast;
                    out_valid_next         = 1'b1;
                    state_next             = StIdle;
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= StIdle;
            hit_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hit_count_reg <= hit_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        out_reg  <= out_next;
    end

    assign bars.ready = (state_reg == StIdle);
    assign hits.valid = out_valid_reg;
    assign hits.data  = out_reg;

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bar_hit_filter_geomean. Bar words go in through a
// bursty driver, and hit words come out through a stalling receiver. Each
// accepted bar word runs through an in-bench filter model, and every hit word
// is compared as a whole word against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb;

    localparam int BarCount   = 32;
    localparam int EventCap   = (BarCount < bhf_pkg::CountMax) ? BarCount : bhf_pkg::CountMax;
    localparam int ItemTarget = 1450;
    localparam int IdleLimit  = 2000;
    localparam int DrainWait  = 40;
    localparam int ShowMax    = 10;

    logic clk;
    logic rst_n;

    bhf_bar_if bars ();
    bhf_hit_if hits ();

    bar_hit_filter_geomean #(.BAR_COUNT(BarCount)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .bars  (bars),
        .hits  (hits)
    );

    bhf_pkg::bar_word_t               bar_words_q[$];
    bhf_pkg::hit_word_t               hit_words_q[$];
    logic [bhf_pkg::CountWidth-1:0]   event_hits;
    bit                               bar_fire;
    int                               errors;
    int                               idle_cycles;
    int                               gap_left;
    int                               burst_left;
    int                               ready_hold;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Q12.4 root: floor(sqrt(a*b << 8)), built bit by bit from the top
    function automatic logic [bhf_pkg::RootWidth-1:0] q4_root(
        input logic [bhf_pkg::ChargeWidth-1:0] a,
        input logic [bhf_pkg::ChargeWidth-1:0] b);
        logic [63:0]                   radicand;
        logic [63:0]                   trial;
        logic [bhf_pkg::RootWidth-1:0] root;
        radicand = ({52'd0, a} * {52'd0, b}) << 8;
        root     = '0;
        for (int i = bhf_pkg::RootWidth - 1; i >= 0; i--)
        begin
            trial = {48'd0, root} | (64'd1 << i);
            if (trial * trial <= radicand)
                root = trial[bhf_pkg::RootWidth-1:0];
        end
        return root;
    endfunction

    // Updates the per-event hit count; returns 1 when the word yields a hit word.
    function automatic bit filter_bar(input bhf_pkg::bar_word_t w,
                                      output bhf_pkg::hit_word_t r);
        bit hit;
        r   = '0;
        hit = w.common_left != 0 && w.common_right != 0 &&
              w.time_left_present && w.time_right_present &&
              w.bar_index < BarCount && event_hits < EventCap;
        if (!hit && !w.event_last)
            return 1'b0;
        if (hit)
        begin
            r.hit_slot         = event_hits[bhf_pkg::BarWidth-1:0];
            r.hit_bar          = w.bar_index;
            r.out_common_left  = w.common_left;
            r.out_common_right = w.common_right;
            r.out_fast_left    = w.fast_left;
            r.out_fast_right   = w.fast_right;
            r.out_time_left    = w.time_left;
            r.out_time_right   = w.time_right;
            r.geo_mean         = q4_root(w.common_left, w.common_right);
            if (w.fast_left != 0 && w.fast_right != 0)
                r.fast_geo_mean = q4_root(w.fast_left, w.fast_right);
            r.is_hit   = 1'b1;
            event_hits = event_hits + 1'b1;
        end
        if (w.event_last)
        begin
            r.event_end = 1'b1;
            event_hits  = '0;
        end
        return 1'b1;
    endfunction

    function automatic string hit_text(input bhf_pkg::hit_word_t h);
        return $sformatf({"slot=%0d bar=%0d cl=%0d cr=%0d fl=%0d fr=%0d tl=%0d tr=%0d ",
                          "geo=%0d fgeo=%0d hit=%0b end=%0b"},
                         h.hit_slot, h.hit_bar, h.out_common_left, h.out_common_right,
                         h.out_fast_left, h.out_fast_right, h.out_time_left,
                         h.out_time_right, h.geo_mean, h.fast_geo_mean, h.is_hit,
                         h.event_end);
    endfunction

    task automatic add_bar(input int bar, input int cl, input int cr, input int fl,
                           input int fr, input int tl, input int tr, input bit tlp,
                           input bit trp, input bit last);
        bhf_pkg::bar_word_t w;
        w.bar_index          = bar[bhf_pkg::BarWidth-1:0];
        w.common_left        = cl[bhf_pkg::ChargeWidth-1:0];
        w.common_right       = cr[bhf_pkg::ChargeWidth-1:0];
        w.fast_left          = fl[bhf_pkg::ChargeWidth-1:0];
        w.fast_right         = fr[bhf_pkg::ChargeWidth-1:0];
        w.time_left          = tl[bhf_pkg::TimeWidth-1:0];
        w.time_right         = tr[bhf_pkg::TimeWidth-1:0];
        w.time_left_present  = tlp;
        w.time_right_present = trp;
        w.event_last         = last;
        bar_words_q.push_back(w);
    endtask

    function automatic int rand_charge();
        case ($urandom_range(0, 9))
            0:       return 4095;
            1:       return $urandom_range(1, 15);
            default: return $urandom_range(1, 4095);
        endcase
    endfunction

    // One event of n bars; about hit_pct percent of them well formed hits, the rest mostly broken.
    task automatic add_event(input int n, input int hit_pct);
        int cl, cr, fl, fr;
        bit tlp, trp;
        for (int i = 0; i < n; i++)
        begin
            cl  = rand_charge();
            cr  = rand_charge();
            fl  = ($urandom_range(0, 4) == 0) ? 0 : rand_charge();
            fr  = ($urandom_range(0, 4) == 0) ? 0 : rand_charge();
            tlp = 1'b1;
            trp = 1'b1;
            if ($urandom_range(0, 99) >= hit_pct)
            begin
                case ($urandom_range(0, 4))
                    0: cl = 0;
                    1: cr = 0;
                    2: tlp = 1'b0;
                    3: trp = 1'b0;
                    default:
                    begin
                        cl  = $urandom_range(0, 1) ? 0 : $urandom_range(0, 4095);
                        cr  = $urandom_range(0, 4095);
                        tlp = $urandom_range(0, 1) != 0;
                        trp = $urandom_range(0, 1) != 0;
                    end
                endcase
            end
            add_bar($urandom_range(0, 31), cl, cr, fl, fr, $urandom_range(0, 2097151),
                    $urandom_range(0, 2097151), tlp, trp, i == n - 1);
        end
    endtask

    // Driver: bursts of words with random gaps in between
    always @(negedge clk)
    begin
        logic               next_valid;
        bhf_pkg::bar_word_t next_data;
        next_valid = bars.valid;
        next_data  = bars.data;
        if (!rst_n)
            next_valid = 1'b0;
        else
        begin
            if (bar_fire)
                next_valid = 1'b0;
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (bar_words_q.size() > 0)
                begin
                    next_data  = bar_words_q.pop_front();
                    next_valid = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        case ($urandom_range(0, 9))
                            4, 5, 6, 7: gap_left = $urandom_range(1, 6);
                            8:          gap_left = $urandom_range(10, 30);
                            default:    gap_left = 0;
                        endcase
                    end
                end
            end
        end
        bars.valid <= next_valid;
        bars.data  <= next_data;
    end

    // Receiver: runs of ready and stalls of random length, long ones now and then
    always @(negedge clk)
    begin
        logic next_ready;
        next_ready = hits.ready;
        if (ready_hold > 0)
            ready_hold--;
        else
        begin
            next_ready = $urandom_range(0, 3) != 0;
            if (next_ready)
                ready_hold = $urandom_range(1, 50);
            else
                ready_hold = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 4);
        end
        hits.ready <= next_ready;
    end

    // Monitor: checks hit words, then predicts from the bar word taken this edge
    always @(posedge clk or negedge rst_n)
    begin
        bhf_pkg::hit_word_t predicted;
        bhf_pkg::hit_word_t oldest;
        if (!rst_n)
        begin
            event_hits  = '0;
            bar_fire    = 1'b0;
            idle_cycles = 0;
        end
        else
        begin
            if (hits.valid && hits.ready)
            begin
                if (hit_words_q.size() == 0)
                begin
                    errors++;
                    if (errors <= ShowMax)
                        $display("unexpected hit word: %s", hit_text(hits.data));
                end
                else
                begin
                    oldest = hit_words_q.pop_front();
                    if (hits.data !== oldest)
                    begin
                        errors++;
                        if (errors <= ShowMax)
                        begin
                            $display("hit word mismatch");
                            $display("  exp %s", hit_text(oldest));
                            $display("  got %s", hit_text(hits.data));
                        end
                    end
                end
            end
            bar_fire = bars.valid && bars.ready;
            if (bar_fire && filter_bar(bars.data, predicted))
                hit_words_q.push_back(predicted);

            if (bar_fire || (hits.valid && hits.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit)
            begin
                $display("timeout: no word moved for %0d cycles", IdleLimit);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int ev;
        clk        = 1'b0;
        rst_n      = 1'b0;
        bars.valid = 1'b0;
        bars.data  = '0;
        hits.ready = 1'b0;
        errors     = 0;
        gap_left   = 0;
        burst_left = 0;
        ready_hold = 0;
        ev         = 0;

        // directed: extremes, fast zero cases, each failed charge and time test, event closes
        add_bar(31, 4095, 4095, 4095, 4095, 2097151, 2097151, 1, 1, 0);
        add_bar(0, 1, 1, 1, 1, 0, 0, 1, 1, 0);
        add_bar(7, 4095, 1, 0, 4095, 12345, 2097151, 1, 1, 0);
        add_bar(24, 1, 4095, 4095, 0, 2097151, 0, 1, 1, 0);
        add_bar(3, 0, 4095, 4095, 4095, 1000, 2000, 1, 1, 0);
        add_bar(4, 4095, 0, 4095, 4095, 1000, 2000, 1, 1, 0);
        add_bar(5, 2000, 3000, 100, 200, 1398101, 699050, 0, 1, 0);
        add_bar(6, 2000, 3000, 100, 200, 699050, 1398101, 1, 0, 0);
        add_bar(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_bar(21, 2730, 1365, 2730, 1365, 1398101, 699050, 1, 1, 1);
        add_bar(0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        add_bar(31, 0, 4095, 4095, 4095, 2097151, 2097151, 1, 1, 1);
        add_bar(10, 3000, 3001, 0, 0, 77, 88, 1, 1, 1);
        add_bar(2, 4095, 4095, 1, 4095, 5, 6, 0, 0, 1);

        // random events; every tenth one has more bars than there are hit slots
        while (bar_words_q.size() < ItemTarget)
        begin
            if (ev % 10 == 5)
                add_event($urandom_range(EventCap + 1, EventCap + 6), 92);
            else
                add_event($urandom_range(1, 12), 70);
            ev++;
        end

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        while (bar_words_q.size() > 0 || bars.valid || hit_words_q.size() > 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);

        if (errors == 0 && hit_words_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> bar_hit_filter_geomean.f
hw/rtl/bhf_pkg.sv
hw/rtl/bhf_if.sv
hw/rtl/bhf_mul.sv
hw/rtl/bhf_sqrt.sv
hw/rtl/bar_hit_filter_geomean.sv
tb/sv/tb.sv
